[hw/rtl/sigmoid_activation_unit_macros.svh]
// Assertion macros used by the checker of the sigmoid activation unit.
`ifndef SIGMOID_ACTIVATION_UNIT_MACROS_SVH
`define SIGMOID_ACTIVATION_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SAU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define SAU_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sau_pkg.sv]
// Package with the constants, the sigmoid table and the shared types of the unit.
`timescale 1ns / 1ps
package sau_pkg;

  localparam int TABLE_BITS = 8;
  localparam int FRAC_BITS  = TABLE_BITS - 3;
  localparam int SEG_SHIFT  = 15 - TABLE_BITS;
  localparam int TABLE_LEN  = (1 << TABLE_BITS) + 1;
  localparam int IDX_W      = TABLE_BITS + 1;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = DATA_W + SEG_SHIFT;
  localparam int NUM_STAGES = 4;

  localparam real HALF_STEP = 0.5 / real'(1 << FRAC_BITS);

  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_BWD = 1'b1;

  localparam logic [DATA_W:0] ONE_Q16 = 17'h10000;

  typedef logic [DATA_W-1:0] rom_t [TABLE_LEN];

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

  // The logistic function is written as one half plus one half of tanh(x/2).
  function automatic logic [DATA_W-1:0] sig_entry(input int j);
    real xh;
    real v;
    int  r;
    xh = real'(j) * HALF_STEP;
    v  = 32768.0 + 32768.0 * $tanh(xh);
    r  = int'($floor(v + 0.5));
    if (r > 65535) begin
      r = 65535;
    end
    return DATA_W'(r);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int j = 0; j < TABLE_LEN; j++) begin
      t[j] = sig_entry(j);
    end
    return t;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

[hw/rtl/sau_in_if.sv]
// Request channel carrying one operand set into the unit.
`timescale 1ns / 1ps
interface sau_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic signed [15:0] x_in;
  logic        [15:0] y_saved;
  logic signed [15:0] grad_in;
  logic signed [15:0] grad_acc;

  modport source (output valid, cmd, x_in, y_saved, grad_in, grad_acc, input ready);
  modport sink   (input valid, cmd, x_in, y_saved, grad_in, grad_acc, output ready);
endinterface

[hw/rtl/sau_out_if.sv]
// Result channel carrying one result out of the unit.
`timescale 1ns / 1ps
interface sau_out_if;
  logic        valid;
  logic        ready;
  logic        [15:0] y_out;
  logic signed [15:0] grad_out;
  logic        saturated;

  modport source (output valid, y_out, grad_out, saturated, input ready);
  modport sink   (input valid, y_out, grad_out, saturated, output ready);
endinterface

[hw/rtl/sau_ctrl.sv]
// Valid and command pipeline with per-stage flow control.
`timescale 1ns / 1ps
module sau_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  logic                out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output logic                out_cmd,
  output sau_pkg::pipe_ctrl_t ctrl
);

  logic [sau_pkg::NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [sau_pkg::NUM_STAGES-1:0] cmd_r, cmd_nxt;
  logic [sau_pkg::NUM_STAGES-1:0] stage_rdy;

  always_comb begin
    stage_rdy[sau_pkg::NUM_STAGES-1] = !valid_r[sau_pkg::NUM_STAGES-1] || out_ready;
    for (int i = sau_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      stage_rdy[i] = !valid_r[i] || stage_rdy[i+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (stage_rdy[0]) begin
      valid_nxt[0] = in_valid;
      cmd_nxt[0]   = in_cmd;
    end
    for (int i = 1; i < sau_pkg::NUM_STAGES; i++) begin
      if (stage_rdy[i]) begin
        valid_nxt[i] = valid_r[i-1];
        cmd_nxt[i]   = cmd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign in_ready  = stage_rdy[0];
  assign out_valid = valid_r[sau_pkg::NUM_STAGES-1];
  assign out_cmd   = cmd_r[sau_pkg::NUM_STAGES-1];
  assign ctrl.load = stage_rdy;

endmodule

[hw/rtl/sau_fwd_dp.sv]
// Forward datapath: table lookup with linear interpolation and symmetry for negative inputs.
`timescale 1ns / 1ps
module sau_fwd_dp (
  input  logic                clk,
  input  sau_pkg::pipe_ctrl_t ctrl,
  input  logic signed [15:0]  x_in,
  output logic        [15:0]  y_out
);

  logic                                   neg1_r, neg1_nxt;
  logic [sau_pkg::IDX_W-1:0]              k1_r, k1_nxt;
  logic [sau_pkg::SEG_SHIFT-1:0]          f1_r, f1_nxt;
  logic [sau_pkg::DATA_W-1:0]             mag;

  logic                                   neg2_r, last2_r, last2_nxt;
  logic [sau_pkg::SEG_SHIFT-1:0]          f2_r;
  logic [sau_pkg::DATA_W-1:0]             e0_2_r, e0_2_nxt, e1_2_r, e1_2_nxt;
  logic [sau_pkg::IDX_W-1:0]              k_next;

  logic                                   neg3_r;
  logic [sau_pkg::DATA_W-1:0]             e0_3_r, diff;
  logic [sau_pkg::PROD_W-1:0]             prod3_r, prod3_nxt;

  logic [sau_pkg::DATA_W:0]               ysum, ysgn;
  logic [sau_pkg::DATA_W-1:0]             y4_r, y4_nxt;

  // Stage 1: magnitude split into table index and fraction.
  always_comb begin
    mag      = x_in[15] ? (~x_in + 16'd1) : x_in;
    neg1_nxt = x_in[15];
    k1_nxt   = mag[sau_pkg::DATA_W-1:sau_pkg::SEG_SHIFT];
    f1_nxt   = mag[sau_pkg::SEG_SHIFT-1:0];
  end

  // Stage 2: read both neighbouring table entries.
  always_comb begin
    last2_nxt = (k1_r == sau_pkg::IDX_W'(sau_pkg::TABLE_LEN - 1));
    k_next    = last2_nxt ? k1_r : k1_r + 1'b1;
    e0_2_nxt  = sau_pkg::SIG_ROM[k1_r];
    e1_2_nxt  = sau_pkg::SIG_ROM[k_next];
  end

  // Stage 3: scale the step between the entries by the fraction.
  always_comb begin
    diff = '0;
    if (f2_r != '0 && !last2_r && e1_2_r >= e0_2_r) begin
      diff = e1_2_r - e0_2_r;
    end
    prod3_nxt = sau_pkg::PROD_W'(diff) * sau_pkg::PROD_W'(f2_r);
  end

  // Stage 4: add, mirror negative inputs about one half and clamp.
  always_comb begin
    ysum   = {1'b0, e0_3_r}
           + {1'b0, prod3_r[sau_pkg::PROD_W-1:sau_pkg::SEG_SHIFT]};
    ysgn   = neg3_r ? (sau_pkg::ONE_Q16 - ysum) : ysum;
    y4_nxt = ysgn[sau_pkg::DATA_W] ? '1 : ysgn[sau_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      neg1_r <= neg1_nxt;
      k1_r   <= k1_nxt;
      f1_r   <= f1_nxt;
    end
    if (ctrl.load[1]) begin
      neg2_r  <= neg1_r;
      f2_r    <= f1_r;
      last2_r <= last2_nxt;
      e0_2_r  <= e0_2_nxt;
      e1_2_r  <= e1_2_nxt;
    end
    if (ctrl.load[2]) begin
      neg3_r  <= neg2_r;
      e0_3_r  <= e0_2_r;
      prod3_r <= prod3_nxt;
    end
    if (ctrl.load[3]) begin
      y4_r <= y4_nxt;
    end
  end

  assign y_out = y4_r;

endmodule

[hw/rtl/sau_bwd_dp.sv]
// Backward datapath: gradient times y(1-y), accumulated with saturation.
`timescale 1ns / 1ps
module sau_bwd_dp (
  input  logic                clk,
  input  sau_pkg::pipe_ctrl_t ctrl,
  input  logic        [15:0]  y_saved,
  input  logic signed [15:0]  grad_in,
  input  logic signed [15:0]  grad_acc,
  output logic signed [15:0]  grad_out,
  output logic                saturated
);

  logic        [15:0] y1_r;
  logic        [16:0] u1_r, u1_nxt;
  logic signed [15:0] dy1_r, acc1_r;

  logic        [33:0] m_full;
  logic        [30:0] m2_r, m2_nxt;
  logic signed [15:0] dy2_r, acc2_r;

  logic signed [47:0] p3_r, p3_nxt;
  logic signed [15:0] acc3_r;

  logic        [15:0] d;
  logic        [16:0] s;
  logic signed [15:0] grad4_r, grad4_nxt;
  logic               sat4_r, sat4_nxt;

  assign u1_nxt = sau_pkg::ONE_Q16 - {1'b0, y_saved};

  // y(1-y) peaks at one quarter, so 31 bits hold it.
  always_comb begin
    m_full = 34'(y1_r) * 34'(u1_r);
    m2_nxt = m_full[30:0];
  end

  assign p3_nxt = $signed(dy2_r) * $signed({1'b0, m2_r});

  // The top bits of the product are its floor after the shift by 32.
  always_comb begin
    d         = p3_r[47:32];
    s         = {acc3_r[15], acc3_r} + {d[15], d};
    sat4_nxt  = s[16] != s[15];
    grad4_nxt = s[15:0];
    if (sat4_nxt) begin
      grad4_nxt = s[16] ? 16'sh8000 : 16'sh7FFF;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      y1_r   <= y_saved;
      u1_r   <= u1_nxt;
      dy1_r  <= grad_in;
      acc1_r <= grad_acc;
    end
    if (ctrl.load[1]) begin
      m2_r   <= m2_nxt;
      dy2_r  <= dy1_r;
      acc2_r <= acc1_r;
    end
    if (ctrl.load[2]) begin
      p3_r   <= p3_nxt;
      acc3_r <= acc2_r;
    end
    if (ctrl.load[3]) begin
      grad4_r <= grad4_nxt;
      sat4_r  <= sat4_nxt;
    end
  end

  assign grad_out  = grad4_r;
  assign saturated = sat4_r;

endmodule

[hw/rtl/sigmoid_activation_unit.sv]
// Top level of the fixed-point sigmoid unit with its backward gradient path.
//
//   Channel   Direction  Contents
//   in_chan   sink       cmd, x_in, y_saved, grad_in, grad_acc
//   out_chan  source     y_out, grad_out, saturated
//
// One request is taken in every cycle unless a stall holds the first stage; its result
// passes through the register stages and is presented from the last one.
// The four register stages each hold a valid bit, so bubbles close up under backpressure.
// A stall at the output holds only the stages that are full behind it.
// Reset clears the valid bits; no request is lost or repeated across a stall.
`timescale 1ns / 1ps
module sigmoid_activation_unit (
  input  logic       clk,
  input  logic       rst_n,
  sau_in_if.sink     in_chan,
  sau_out_if.source  out_chan
);

  sau_pkg::pipe_ctrl_t ctrl;
  logic                out_cmd;
  logic        [15:0]  fwd_y;
  logic signed [15:0]  bwd_grad;
  logic                bwd_sat;

  sau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.cmd),
    .out_ready (out_chan.ready),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_cmd   (out_cmd),
    .ctrl      (ctrl)
  );

  sau_fwd_dp u_fwd (
    .clk   (clk),
    .ctrl  (ctrl),
    .x_in  (in_chan.x_in),
    .y_out (fwd_y)
  );

  sau_bwd_dp u_bwd (
    .clk       (clk),
    .ctrl      (ctrl),
    .y_saved   (in_chan.y_saved),
    .grad_in   (in_chan.grad_in),
    .grad_acc  (in_chan.grad_acc),
    .grad_out  (bwd_grad),
    .saturated (bwd_sat)
  );

  assign out_chan.y_out     = (out_cmd == sau_pkg::CMD_FWD) ? fwd_y : '0;
  assign out_chan.grad_out  = (out_cmd == sau_pkg::CMD_BWD) ? bwd_grad : '0;
  assign out_chan.saturated = (out_cmd == sau_pkg::CMD_BWD) ? bwd_sat : 1'b0;

endmodule

[hw/rtl/sau_checker.sv]
// Port-level checker for the sigmoid unit, bound to the top level.
`timescale 1ns / 1ps
`include "sigmoid_activation_unit_macros.svh"
module sau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [15:0] y_out,
  input logic signed [15:0] grad_out,
  input logic               saturated
);

  `SAU_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result shown straight after reset")
  `SAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(y_out) && $stable(grad_out) && $stable(saturated), "stalled result changed")
  `SAU_ASSERT_IMPLIES(a_fwd_clean, clk, rst_n, out_valid && y_out != 16'd0, grad_out == 16'sd0 && !saturated, "forward result carries gradient fields")
  `SAU_ASSERT_IMPLIES(a_sat_bound, clk, rst_n, out_valid && saturated, grad_out == 16'sh7FFF || grad_out == 16'sh8000, "saturated gradient not at a bound")

endmodule

bind sigmoid_activation_unit sau_checker u_sau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .y_out     (out_chan.y_out),
  .grad_out  (out_chan.grad_out),
  .saturated (out_chan.saturated)
);

[bench/tb_sigmoid_activation_unit.sv]
// Testbench of the sigmoid activation unit: directed and random requests against a predictor.
`timescale 1ns / 1ps
module tb_sigmoid_activation_unit;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic               cmd;
    logic signed [15:0] x_in;
    logic        [15:0] y_saved;
    logic signed [15:0] grad_in;
    logic signed [15:0] grad_acc;
  } act_request_t;

  typedef struct {
    logic        [15:0] y_out;
    logic signed [15:0] grad_out;
    logic               saturated;
  } act_result_t;

  class sigmoid_scoreboard;
    int unsigned  sig_lut [sau_pkg::TABLE_LEN];
    act_result_t  awaited_q [$];
    int           error_count;

    function new();
      real e;
      real v;
      for (int j = 0; j < sau_pkg::TABLE_LEN; j++) begin
        e = $exp(real'(j) / real'(1 << sau_pkg::FRAC_BITS));
        v = 65536.0 * e / (e + 1.0);
        sig_lut[j] = $rtoi(v + 0.5);
        if (sig_lut[j] > 65535) begin
          sig_lut[j] = 65535;
        end
      end
      error_count = 0;
    endfunction

    function act_result_t predict_activation(act_request_t r);
      act_result_t res;
      int          mag;
      int          idx;
      int          frac;
      int unsigned yv;
      longint      yl;
      longint      prod;
      longint      sum;
      res.y_out     = '0;
      res.grad_out  = '0;
      res.saturated = 1'b0;
      if (r.cmd == sau_pkg::CMD_FWD) begin
        mag  = (r.x_in < 0) ? -int'(r.x_in) : int'(r.x_in);
        idx  = mag >> sau_pkg::SEG_SHIFT;
        frac = mag & ((1 << sau_pkg::SEG_SHIFT) - 1);
        if (idx > sau_pkg::TABLE_LEN - 1) begin
          idx = sau_pkg::TABLE_LEN - 1;
        end
        yv = sig_lut[idx];
        if (frac != 0 && idx + 1 < sau_pkg::TABLE_LEN && sig_lut[idx+1] >= sig_lut[idx]) begin
          yv += ((sig_lut[idx+1] - sig_lut[idx]) * frac) >> sau_pkg::SEG_SHIFT;
        end
        if (r.x_in < 0) begin
          yv = 65536 - yv;
        end
        if (yv > 65535) begin
          yv = 65535;
        end
        res.y_out = yv[15:0];
      end else begin
        yl   = {48'b0, r.y_saved};
        prod = longint'(r.grad_in) * (yl * (65536 - yl));
        sum  = longint'(r.grad_acc) + (prod >>> 32);
        if (sum > 32767) begin
          sum           = 32767;
          res.saturated = 1'b1;
        end else if (sum < -32768) begin
          sum           = -32768;
          res.saturated = 1'b1;
        end
        res.grad_out = sum[15:0];
      end
      return res;
    endfunction

    function void note_request(act_request_t r);
      awaited_q.push_back(predict_activation(r));
    endfunction

    function void check_result(act_result_t got);
      act_result_t want;
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual y_out %0d grad_out %0d sat %0b",
                 $time, got.y_out, got.grad_out, got.saturated);
        error_count++;
        return;
      end
      want = awaited_q.pop_front();
      if (got.y_out !== want.y_out) begin
        $display("%0t: y_out mismatch, expected %0d, actual %0d",
                 $time, want.y_out, got.y_out);
        error_count++;
      end
      if (got.grad_out !== want.grad_out) begin
        $display("%0t: grad_out mismatch, expected %0d, actual %0d",
                 $time, want.grad_out, got.grad_out);
        error_count++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated mismatch, expected %0b, actual %0b",
                 $time, want.saturated, got.saturated);
        error_count++;
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  int   stall_left;
  int   cycle_count;

  sau_in_if  in_if ();
  sau_out_if out_if ();

  sigmoid_scoreboard sb;

  sigmoid_activation_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result('{out_if.y_out, out_if.grad_out, out_if.saturated});
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic act_request_t fwd_request(logic signed [15:0] x);
    return '{sau_pkg::CMD_FWD, x, 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic act_request_t bwd_request(logic [15:0] y, logic signed [15:0] g,
                                               logic signed [15:0] acc);
    return '{sau_pkg::CMD_BWD, 16'($urandom), y, g, acc};
  endfunction

  task automatic send_request(act_request_t r);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.cmd      <= r.cmd;
    in_if.x_in     <= r.x_in;
    in_if.y_saved  <= r.y_saved;
    in_if.grad_in  <= r.grad_in;
    in_if.grad_acc <= r.grad_acc;
    in_if.valid    <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    sb.note_request(r);
  endtask

  function automatic act_request_t random_request();
    logic signed [15:0] x;
    logic        [15:0] y;
    case ($urandom_range(0, 3))
      0: x = 16'($urandom_range(0, 4095)) - 16'sd2048;
      1: x = 16'($urandom) & 16'hff80;
      default: x = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: y = 16'($urandom_range(0, 15));
      1: y = 16'($urandom_range(65520, 65535));
      2: y = 16'($urandom_range(30000, 35536));
      default: y = 16'($urandom);
    endcase
    if ($urandom_range(0, 1) == 0) begin
      return fwd_request(x);
    end
    return bwd_request(y, 16'($urandom), 16'($urandom));
  endfunction

  initial begin
    act_request_t directed_q [$];
    sb             = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    quiet          = 1'b0;
    stall_left     = 0;
    cycle_count    = 0;
    in_if.valid    = 1'b0;
    in_if.cmd      = sau_pkg::CMD_FWD;
    in_if.x_in     = '0;
    in_if.y_saved  = '0;
    in_if.grad_in  = '0;
    in_if.grad_acc = '0;
    out_if.ready   = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    directed_q = '{fwd_request(16'sd0), fwd_request(16'sd1), fwd_request(-16'sd1),
                   fwd_request(16'sd32767), fwd_request(-16'sd32768), fwd_request(16'sd128),
                   fwd_request(-16'sd128), fwd_request(16'sd127), fwd_request(16'sd4096),
                   fwd_request(-16'sd4096), fwd_request(16'sd32640), fwd_request(-16'sd20000),
                   bwd_request(16'd32768, 16'sd32767, 16'sd32767),
                   bwd_request(16'd32768, -16'sd32768, -16'sd32768),
                   bwd_request(16'd32768, 16'sd32767, 16'sd24576),
                   bwd_request(16'd0, 16'sd32767, 16'sd100),
                   bwd_request(16'd65535, -16'sd32768, 16'sd0),
                   bwd_request(16'd1, -16'sd1, 16'sd0),
                   bwd_request(16'd32768, 16'sd4096, 16'sd0),
                   bwd_request(16'd40000, -16'sd12345, -16'sd32668),
                   bwd_request(16'd65535, 16'sd32767, -16'sd32768)};
    foreach (directed_q[i]) begin
      send_request(directed_q[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet = 1'b1;
      end
      send_request(random_request());
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (2 * sau_pkg::NUM_STAGES + 4) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
